// ----- rtl/meg_pkg.sv -----
package meg_pkg;

	localparam int LEVEL_BITS     = 24;
	localparam int FRAC_BITS      = 16;
	localparam int RATE_W         = FRAC_BITS + 2;
	localparam int STRETCH_W      = 20;
	localparam int STRETCH_FRAC   = 16;
	localparam int IDX_W          = 6;
	localparam int NUM_W          = IDX_W + 1;
	localparam int CFG_W          = 20;
	localparam int MAX_POINTS_DEF = 40;

	localparam logic [RATE_W-1:0]    RATE_CAP      = {2'b10, {FRAC_BITS{1'b0}}};
	localparam logic [STRETCH_W-1:0] STRETCH_RESET = STRETCH_W'(65536);
	localparam logic [IDX_W-1:0]     COUNT_RESET   = IDX_W'(2);

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_LOAD    = 2'd2,
		ACT_START   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_POINT_COUNT   = 2'd0,
		CFG_SUSTAIN_POINT = 2'd1,
		CFG_FORCED        = 2'd2,
		CFG_STRETCH       = 2'd3
	} cfg_index_t;

	typedef struct packed {
		action_t                      action;
		logic [IDX_W-1:0]             point_index;
		logic signed [LEVEL_BITS-1:0] point_level;
		logic [RATE_W-1:0]            point_rate;
	} meg_cmd_t;

	typedef struct packed {
		logic signed [LEVEL_BITS-1:0] level;
		logic                         done_res;
	} meg_res_t;

	// a + floor((b - a) * t / unit)
	function automatic logic signed [LEVEL_BITS-1:0] interp(
		input logic signed [LEVEL_BITS-1:0] a,
		input logic signed [LEVEL_BITS-1:0] b,
		input logic [FRAC_BITS-1:0] t
	);
		logic signed [LEVEL_BITS:0]             d;
		logic signed [LEVEL_BITS+FRAC_BITS+1:0] p;
		logic signed [LEVEL_BITS+1:0]           q;
		logic signed [LEVEL_BITS+1:0]           s;
		d = {b[LEVEL_BITS-1], b} - {a[LEVEL_BITS-1], a};
		p = d * $signed({1'b0, t});
		q = p[LEVEL_BITS+FRAC_BITS+1:FRAC_BITS];
		s = {{2{a[LEVEL_BITS-1]}}, a} + q;
		return s[LEVEL_BITS-1:0];
	endfunction

endpackage

// ----- rtl/multipoint_envelope_generator.sv -----
// channel  direction  handshake              payload
// cmd      in         cmd_valid / cmd_stall  meg_cmd_t (action, point_index, point_level, point_rate)
// res      out        res_valid / res_stall  meg_res_t (level, done_res)
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle while cmd_stall is low: an item is held in the input register, and a tick's result
// is then written to the result register.
// table reads are registered and always track the next state, so a tick finds its
// points ready whatever came before it; loads are forwarded into the read registers.
// reset clears the envelope state, the configuration and the valid flags; the point tables hold nothing
// until loaded and get no clearing pass.
// cmd_stall rises only while a tick waits in the input register behind a stalled result;
// cfg_ready is always high.
module multipoint_envelope_generator import meg_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  meg_cmd_t             cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output meg_res_t             res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  cfg_index_t           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int SEG_W = $clog2(MAX_POINTS + 1);
	localparam int PS_W  = RATE_W + STRETCH_W - STRETCH_FRAC + 1;
	localparam logic [NUM_W-1:0] MAXP = NUM_W'(MAX_POINTS);

	typedef struct packed {
		logic [NUM_W-1:0] pc;
		logic             has_sus;
		logic [NUM_W-1:0] tgt;
		logic [NUM_W-1:0] relseg;
	} geom_t;

	function automatic geom_t geom(input logic [IDX_W-1:0] pcount, input logic [IDX_W-1:0] sus);
		logic [NUM_W-1:0] p;
		logic [NUM_W-1:0] s;
		geom_t            g;
		p = {1'b0, pcount};
		s = {1'b0, sus};
		if (p < NUM_W'(2)) begin
			p = NUM_W'(2);
		end else if (p > MAXP) begin
			p = MAXP;
		end
		g.pc      = p;
		g.has_sus = (s >= NUM_W'(1)) && (s + NUM_W'(2) <= p);
		g.tgt     = g.has_sus ? s + NUM_W'(1) : p - NUM_W'(1);
		g.relseg  = g.has_sus ? s + NUM_W'(2) : NUM_W'(1);
		return g;
	endfunction

	function automatic logic [NUM_W-1:0] seg_clamp(input logic [SEG_W-1:0] sv);
		logic [NUM_W-1:0] v;
		v = NUM_W'(sv);
		if (v < NUM_W'(1)) begin
			v = NUM_W'(1);
		end else if (v > MAXP - NUM_W'(1)) begin
			v = MAXP - NUM_W'(1);
		end
		return v;
	endfunction

	function automatic logic [AW-1:0] addr_clamp(input logic [NUM_W-1:0] v);
		logic [AW-1:0] a;
		if (v > MAXP - NUM_W'(1)) begin
			a = AW'(MAX_POINTS - 1);
		end else begin
			a = v[AW-1:0];
		end
		return a;
	endfunction

	// configuration
	logic [IDX_W-1:0]     pcount_q, pcount_d;
	logic [IDX_W-1:0]     sus_q, sus_d;
	logic                 forced_q;
	logic [STRETCH_W-1:0] stretch_q;

	assign cfg_ready = 1'b1;
	assign pcount_d  = (cfg_valid && cfg_index == CFG_POINT_COUNT) ? cfg_data[IDX_W-1:0] : pcount_q;
	assign sus_d     = (cfg_valid && cfg_index == CFG_SUSTAIN_POINT) ? cfg_data[IDX_W-1:0] : sus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q  <= COUNT_RESET;
			sus_q     <= '0;
			forced_q  <= 1'b0;
			stretch_q <= STRETCH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_POINT_COUNT:   pcount_q  <= cfg_data[IDX_W-1:0];
				CFG_SUSTAIN_POINT: sus_q     <= cfg_data[IDX_W-1:0];
				CFG_FORCED:        forced_q  <= cfg_data[0];
				CFG_STRETCH:       stretch_q <= cfg_data[STRETCH_W-1:0];
				default:           pcount_q  <= pcount_q;
			endcase
		end
	end

	// input register and result register
	meg_cmd_t s1_q;
	logic     s1_valid_q;
	logic     s1_fire;
	logic     s1_tick;
	logic     accept;
	meg_res_t res_q;
	logic     res_valid_q;

	assign s1_tick   = s1_q.action == ACT_TICK;
	assign s1_fire   = s1_valid_q && !(s1_tick && res_valid_q && res_stall);
	assign cmd_stall = s1_valid_q && !s1_fire;
	assign accept    = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= cmd;
		end
	end

	// envelope state
	logic [SEG_W-1:0]             seg_q, seg_n, seg_d;
	logic [FRAC_BITS-1:0]         phase_q, phase_n;
	logic [RATE_W-1:0]            step_q, step_n;
	logic signed [LEVEL_BITS-1:0] held_q, held_n;
	logic                         kr_q, kr_n, kr_d;
	logic                         rp_q, rp_n, rp_d;
	logic                         fin_q, fin_n, fin_d;
	logic                         sflag_q, sflag_n;

	// table read ports
	logic signed [LEVEL_BITS-1:0] lvl_mem [MAX_POINTS];
	logic [RATE_W-1:0]            rate_mem [MAX_POINTS];
	logic signed [LEVEL_BITS-1:0] la_data, lb_data;
	logic [RATE_W-1:0]            ra_data, rb_data;
	logic [AW-1:0]                la, lb, ra, rb, wa;
	logic                         we;
	logic signed [LEVEL_BITS-1:0] wlvl;
	logic [RATE_W-1:0]            wrate;

	assign we    = s1_fire && s1_q.action == ACT_LOAD && ({1'b0, s1_q.point_index} < MAXP);
	assign wa    = s1_q.point_index[AW-1:0];
	assign wlvl  = s1_q.point_level;
	assign wrate = (s1_q.point_rate > RATE_CAP) ? RATE_CAP : s1_q.point_rate;

	always_ff @(posedge clk) begin
		if (we) begin
			lvl_mem[wa]  <= wlvl;
			rate_mem[wa] <= wrate;
		end
		la_data <= (we && wa == la) ? wlvl : lvl_mem[la];
		lb_data <= (we && wa == lb) ? wlvl : lvl_mem[lb];
		ra_data <= (we && wa == ra) ? wrate : rate_mem[ra];
		rb_data <= (we && wa == rb) ? wrate : rate_mem[rb];
	end

	// tick datapath on current state
	geom_t                               gq;
	logic [NUM_W-1:0]                    ic;
	logic                                hold;
	logic [RATE_W-1:0]                   step_base;
	logic [RATE_W+STRETCH_W-1:0]         rel_prod;
	logic [PS_W-1:0]                     psum_rel;
	logic [RATE_W:0]                     psum_nrm;
	logic signed [LEVEL_BITS-1:0]        ia, ib, iv;
	logic signed [LEVEL_BITS-1:0]        res_lvl;

	assign gq        = geom(pcount_q, sus_q);
	assign ic        = seg_clamp(seg_q);
	assign hold      = gq.has_sus && (NUM_W'(seg_q) == {1'b0, sus_q} + NUM_W'(1)) && !kr_q;
	assign step_base = sflag_q ? ra_data : step_q;
	assign rel_prod  = ra_data * stretch_q;
	assign psum_rel  = PS_W'(phase_q) + PS_W'(rel_prod[RATE_W+STRETCH_W-1:STRETCH_FRAC]);
	assign psum_nrm  = (RATE_W+1)'(phase_q) + (RATE_W+1)'(step_base);
	assign ia        = rp_q ? held_q : la_data;
	assign ib        = rp_q ? la_data : lb_data;
	assign iv        = interp(ia, ib, phase_q);

	always_comb begin
		logic                         seg_end;
		logic                         inst;
		logic signed [LEVEL_BITS-1:0] lvl;
		seg_n   = seg_q;
		phase_n = phase_q;
		step_n  = step_base;
		held_n  = held_q;
		kr_n    = kr_q;
		rp_n    = rp_q;
		fin_n   = fin_q;
		sflag_n = 1'b0;
		seg_end = 1'b0;
		inst    = 1'b0;
		lvl     = la_data;
		case (s1_q.action)
			ACT_TICK: begin
				if (fin_q || hold) begin
					lvl    = la_data;
					held_n = lvl;
				end else if (rp_q) begin
					if (ra_data == '0) begin
						lvl     = la_data;
						seg_end = 1'b1;
					end else begin
						lvl = iv;
						if (psum_rel[PS_W-1:FRAC_BITS] != '0) begin
							seg_end = 1'b1;
						end else begin
							phase_n = psum_rel[FRAC_BITS-1:0];
						end
					end
					if (seg_end) begin
						seg_n   = SEG_W'(gq.relseg);
						rp_n    = 1'b0;
						phase_n = '0;
						step_n  = (gq.relseg < gq.pc) ? rb_data : '0;
						if (!gq.has_sus || gq.relseg >= gq.pc) begin
							fin_n = 1'b1;
						end
					end
				end else begin
					inst = (step_base == '0) || (step_base[RATE_W-1:FRAC_BITS] != '0);
					lvl  = inst ? lb_data : iv;
					if (inst || psum_nrm[RATE_W:FRAC_BITS] != '0) begin
						if (ic >= gq.pc - NUM_W'(1)) begin
							fin_n = 1'b1;
							seg_n = SEG_W'(ic);
						end else begin
							seg_n = SEG_W'(ic + NUM_W'(1));
						end
						phase_n = '0;
						step_n  = rb_data;
					end else begin
						phase_n = psum_nrm[FRAC_BITS-1:0];
					end
					held_n = lvl;
				end
			end
			ACT_RELEASE: begin
				if (!kr_q) begin
					kr_n = 1'b1;
					if (forced_q) begin
						phase_n = '0;
						rp_n    = 1'b1;
					end
				end
			end
			ACT_START: begin
				seg_n   = SEG_W'(1);
				phase_n = '0;
				sflag_n = 1'b1;
				held_n  = '0;
				kr_n    = 1'b0;
				rp_n    = 1'b0;
				fin_n   = 1'b0;
			end
			default: begin
				seg_n = seg_q;
			end
		endcase
		res_lvl = lvl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q   <= SEG_W'(1);
			phase_q <= '0;
			step_q  <= '0;
			held_q  <= '0;
			kr_q    <= 1'b0;
			rp_q    <= 1'b0;
			fin_q   <= 1'b0;
			sflag_q <= 1'b0;
		end else if (s1_fire) begin
			seg_q   <= seg_n;
			phase_q <= phase_n;
			step_q  <= step_n;
			held_q  <= held_n;
			kr_q    <= kr_n;
			rp_q    <= rp_n;
			fin_q   <= fin_n;
			sflag_q <= sflag_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && s1_tick) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_tick) begin
			res_q.level    <= res_lvl;
			res_q.done_res <= fin_n;
		end
	end

	// read addresses follow the state and configuration of the next cycle
	geom_t            gd;
	logic [NUM_W-1:0] icd;
	logic             hold_d;

	assign seg_d  = s1_fire ? seg_n : seg_q;
	assign kr_d   = s1_fire ? kr_n : kr_q;
	assign rp_d   = s1_fire ? rp_n : rp_q;
	assign fin_d  = s1_fire ? fin_n : fin_q;
	assign gd     = geom(pcount_d, sus_d);
	assign icd    = seg_clamp(seg_d);
	assign hold_d = gd.has_sus && (NUM_W'(seg_d) == {1'b0, sus_d} + NUM_W'(1)) && !kr_d;

	always_comb begin
		if (fin_d) begin
			la = addr_clamp(gd.pc - NUM_W'(1));
		end else if (hold_d) begin
			la = addr_clamp({1'b0, sus_d});
		end else if (rp_d) begin
			la = addr_clamp(gd.tgt);
		end else begin
			la = addr_clamp(icd - NUM_W'(1));
		end
		lb = addr_clamp(icd);
		ra = rp_d ? addr_clamp(gd.tgt) : AW'(1);
		rb = rp_d ? addr_clamp(gd.relseg) : addr_clamp(icd + NUM_W'(1));
	end

endmodule
